FILE: rtl/contiguous_free_page_finder_assert.svh
// Assertion macros shared by the contiguous free page finder modules.
`ifndef CONTIGUOUS_FREE_PAGE_FINDER_ASSERT_SVH
`define CONTIGUOUS_FREE_PAGE_FINDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFPF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CFPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cfpf_pkg.sv
// Shared types and constants of the contiguous free page finder.
package cfpf_pkg;

    localparam int WORD_BITS = 32;
    localparam int BIT_IDX_W = 5;
    localparam int OP_W      = 2;
    localparam int TSEL_W    = 6;
    localparam int ESEL_W    = 10;
    localparam int CNT_W     = 11;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_FIND      = 2'd0;
    localparam op_t OP_MARK_USED = 2'd1;
    localparam op_t OP_MARK_FREE = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MARK_RD,
        S_MARK_WR,
        S_CNT_RD,
        S_CNT_CHK,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic mark_rd;
        logic mark_wr;
        logic scan_start;
        logic scan_eval;
        logic scan_step;
        logic next_table;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic want_bad;
        logic table_fits;
        logic hit;
        logic last_word;
        logic last_table;
    } status_t;

endpackage

FILE: rtl/cfpf_ctrl.sv
// Controller state machine of the contiguous free page finder.
`include "contiguous_free_page_finder_assert.svh"

module cfpf_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  cfpf_pkg::op_t        req_op,
    output logic                 req_ready,
    output logic                 res_valid,
    input  logic                 res_ready,
    input  cfpf_pkg::status_t    status,
    output cfpf_pkg::cmd_t       cmd
);

    cfpf_pkg::state_t state_reg;
    cfpf_pkg::state_t state_next;
    logic             res_valid_reg;
    logic             res_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfpf_pkg::S_CLEAR;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cfpf_pkg::S_CLEAR:
            begin
                if (status.clr_done)
                begin
                    state_next = cfpf_pkg::S_IDLE;
                end
            end
            cfpf_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_op) inside
                        cfpf_pkg::OP_FIND:
                            state_next = cfpf_pkg::S_CNT_RD;
                        cfpf_pkg::OP_MARK_USED, cfpf_pkg::OP_MARK_FREE:
                            state_next = cfpf_pkg::S_MARK_RD;
                        default:
                            state_next = cfpf_pkg::S_DONE;
                    endcase
                end
            end
            cfpf_pkg::S_MARK_RD:
                state_next = cfpf_pkg::S_MARK_WR;
            cfpf_pkg::S_MARK_WR:
                state_next = cfpf_pkg::S_DONE;
            cfpf_pkg::S_CNT_RD:
                state_next = status.want_bad ? cfpf_pkg::S_DONE : cfpf_pkg::S_CNT_CHK;
            cfpf_pkg::S_CNT_CHK:
            begin
                if (status.table_fits)
                begin
                    state_next = cfpf_pkg::S_SCAN;
                end
                else
                begin
                    state_next = status.last_table ? cfpf_pkg::S_DONE : cfpf_pkg::S_CNT_RD;
                end
            end
            cfpf_pkg::S_SCAN:
            begin
                if (status.hit)
                begin
                    state_next = cfpf_pkg::S_DONE;
                end
                else if (status.last_word)
                begin
                    state_next = status.last_table ? cfpf_pkg::S_DONE : cfpf_pkg::S_CNT_RD;
                end
            end
            cfpf_pkg::S_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    state_next = cfpf_pkg::S_IDLE;
                end
            end
            default:
                state_next = cfpf_pkg::S_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            cfpf_pkg::S_CLEAR:
                cmd.clr_step = 1'b1;
            cfpf_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            cfpf_pkg::S_MARK_RD:
                cmd.mark_rd = 1'b1;
            cfpf_pkg::S_MARK_WR:
                cmd.mark_wr = 1'b1;
            cfpf_pkg::S_CNT_RD:
                cmd = '0;
            cfpf_pkg::S_CNT_CHK:
            begin
                cmd.scan_start = status.table_fits;
                cmd.next_table = !status.table_fits && !status.last_table;
            end
            cfpf_pkg::S_SCAN:
            begin
                cmd.scan_eval  = 1'b1;
                cmd.scan_step  = !status.hit && !status.last_word;
                cmd.next_table = !status.hit && status.last_word && !status.last_table;
            end
            cfpf_pkg::S_DONE:
                cmd.out_load = !res_valid_reg || res_ready;
            default:
                cmd = '0;
        endcase
    end

    // Result register valid: set on load, drop once the receiver takes it.
    always_comb
    begin
        if (cmd.out_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    assign res_valid = res_valid_reg;

    `CFPF_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, req_valid && req_ready, state_reg != cfpf_pkg::S_IDLE, "accepted request did not start work")
    `CFPF_ASSERT_NOW(a_clear_quiet, clk, rst_n, state_reg == cfpf_pkg::S_CLEAR, !req_ready && !res_valid_reg, "activity during clearing pass")

endmodule

FILE: rtl/cfpf_dpath.sv
// Datapath of the contiguous free page finder: used map, used counts, word scanner.
`include "contiguous_free_page_finder_assert.svh"

module cfpf_dpath #(
    parameter int TABLES  = 64,
    parameter int ENTRIES = 1024
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  cfpf_pkg::cmd_t                   cmd,
    output cfpf_pkg::status_t                status,
    input  cfpf_pkg::op_t                    op,
    input  logic [cfpf_pkg::TSEL_W-1:0]      table_sel,
    input  logic [cfpf_pkg::ESEL_W-1:0]      entry_sel,
    input  logic [cfpf_pkg::CNT_W-1:0]       page_count,
    output logic                             found,
    output logic [cfpf_pkg::TSEL_W-1:0]      result_table,
    output logic [cfpf_pkg::ESEL_W-1:0]      result_entry
);

    localparam int WORDS = (ENTRIES + cfpf_pkg::WORD_BITS - 1) / cfpf_pkg::WORD_BITS;
    localparam int DEPTH = TABLES * WORDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = (TABLES > 1) ? $clog2(TABLES) : 1;
    localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int EBW   = WW + cfpf_pkg::BIT_IDX_W;
    localparam int MULW  = cfpf_pkg::TSEL_W + WW + 1;
    localparam int TSW   = (TW > cfpf_pkg::TSEL_W) ? TW : cfpf_pkg::TSEL_W;
    localparam int SUMW  = cfpf_pkg::CNT_W + 1;
    localparam int NB    = cfpf_pkg::WORD_BITS;

    // Storage
    logic [NB-1:0]               map_mem [DEPTH];
    logic [cfpf_pkg::CNT_W-1:0]  cnt_mem [TABLES];

    // Captured request
    cfpf_pkg::op_t               op_reg;
    logic [cfpf_pkg::TSEL_W-1:0] table_sel_reg;
    logic [cfpf_pkg::ESEL_W-1:0] entry_sel_reg;
    logic [cfpf_pkg::CNT_W-1:0]  want_reg;

    // Scan position and clear sweep
    logic [AW-1:0]               clr_reg;
    logic [TW-1:0]               table_reg;
    logic [AW-1:0]               base_reg;
    logic [AW-1:0]               map_addr_reg;
    logic [WW-1:0]               word_idx_reg;
    logic [cfpf_pkg::CNT_W-1:0]  run_reg;
    logic [cfpf_pkg::CNT_W-1:0]  run_next;

    // Registered read data
    logic [NB-1:0]               rd_word_reg;
    logic [cfpf_pkg::CNT_W-1:0]  cnt_rd_reg;

    // Pending result
    logic                        hit_found_reg;
    logic [cfpf_pkg::TSEL_W-1:0] hit_table_reg;
    logic [cfpf_pkg::ESEL_W-1:0] hit_entry_reg;

    // Output payload
    logic                        found_reg;
    logic [cfpf_pkg::TSEL_W-1:0] result_table_reg;
    logic [cfpf_pkg::ESEL_W-1:0] result_entry_reg;

    // Mark path
    logic                        mark_ok;
    logic                        mark_set;
    logic                        cur_bit;
    logic                        map_we;
    logic [MULW-1:0]             mark_prod;
    logic [AW-1:0]               mark_addr;
    logic [TSW-1:0]              tsel_ext;
    logic [TW-1:0]               tsel_idx;
    logic [NB-1:0]               bit_mask;
    logic [NB-1:0]               map_wdata;
    logic [cfpf_pkg::CNT_W-1:0]  cnt_wdata;
    logic [AW-1:0]               rd_addr;
    logic [TW-1:0]               cnt_rd_idx;

    // Word scanner
    logic [EBW-1:0]              entry_base;
    logic [NB-1:0]               free_bits;
    logic [NB-1:0]               hit_vec;
    logic [NB-1:0]               all_free;
    logic [cfpf_pkg::BIT_IDX_W-1:0] last_used [NB];
    logic [SUMW-1:0]             run_tot [NB];
    logic [cfpf_pkg::BIT_IDX_W-1:0] pick;
    logic [SUMW-1:0]             start_sum;
    logic [SUMW-1:0]             free_n;

    // Mark address: table base plus word within the table
    assign tsel_ext  = TSW'(table_sel_reg);
    assign tsel_idx  = tsel_ext[TW-1:0];
    assign mark_ok   = (32'(table_sel_reg) < TABLES) && (32'(entry_sel_reg) < ENTRIES);
    assign mark_set  = (op_reg == cfpf_pkg::OP_MARK_USED);
    assign mark_prod = MULW'(table_sel_reg) * MULW'(WORDS)
                     + MULW'(entry_sel_reg[cfpf_pkg::ESEL_W-1:cfpf_pkg::BIT_IDX_W]);
    assign mark_addr = mark_ok ? AW'(mark_prod) : '0;
    assign bit_mask  = NB'(1) << entry_sel_reg[cfpf_pkg::BIT_IDX_W-1:0];
    assign cur_bit   = |(rd_word_reg & bit_mask);
    assign map_we    = cmd.mark_wr && mark_ok && (mark_set ? !cur_bit : cur_bit);
    assign map_wdata = mark_set ? (rd_word_reg | bit_mask) : (rd_word_reg & ~bit_mask);
    assign cnt_wdata = mark_set ? (cnt_rd_reg + 1'b1) : (cnt_rd_reg - 1'b1);

    always_comb
    begin
        if (cmd.mark_rd)
        begin
            rd_addr = mark_addr;
        end
        else if (cmd.scan_step)
        begin
            rd_addr = map_addr_reg + 1'b1;
        end
        else
        begin
            rd_addr = map_addr_reg;
        end
    end

    assign cnt_rd_idx = cmd.mark_rd ? tsel_idx : table_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            map_mem[clr_reg] <= '0;
        end
        else if (map_we)
        begin
            map_mem[mark_addr] <= map_wdata;
        end
        rd_word_reg <= map_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step && (32'(clr_reg) < TABLES))
        begin
            cnt_mem[clr_reg[TW-1:0]] <= '0;
        end
        else if (map_we)
        begin
            cnt_mem[tsel_idx] <= cnt_wdata;
        end
        cnt_rd_reg <= cnt_mem[cnt_rd_idx];
    end

    // Word scanner: run length ending at each bit, carried in from earlier words
    assign entry_base = {word_idx_reg, {cfpf_pkg::BIT_IDX_W{1'b0}}};

    always_comb
    begin
        for (int i = 0; i < NB; i++)
        begin
            free_bits[i] = !rd_word_reg[i] && ((32'(entry_base) + i) < ENTRIES);
        end
        for (int i = 0; i < NB; i++)
        begin
            all_free[i]  = 1'b1;
            last_used[i] = '0;
            for (int j = 0; j <= i; j++)
            begin
                if (!free_bits[j])
                begin
                    all_free[i]  = 1'b0;
                    last_used[i] = cfpf_pkg::BIT_IDX_W'(j);
                end
            end
            run_tot[i] = all_free[i]
                       ? (SUMW'(run_reg) + SUMW'(i) + 1'b1)
                       : (SUMW'(i) - SUMW'(last_used[i]));
            hit_vec[i] = (run_tot[i] >= SUMW'(want_reg));
        end
        pick = '0;
        for (int i = NB - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                pick = cfpf_pkg::BIT_IDX_W'(i);
            end
        end
    end

    assign start_sum = SUMW'(entry_base) + SUMW'(pick) + 1'b1 - SUMW'(want_reg);
    assign run_next  = cfpf_pkg::CNT_W'(run_tot[NB-1]);
    assign free_n    = SUMW'(ENTRIES) - SUMW'(cnt_rd_reg);

    assign status.clr_done   = (clr_reg == AW'(DEPTH - 1));
    assign status.want_bad   = (want_reg == '0) || (32'(want_reg) > ENTRIES);
    assign status.table_fits = (32'(cnt_rd_reg) < ENTRIES) && (free_n >= SUMW'(want_reg));
    assign status.hit        = |hit_vec;
    assign status.last_word  = (word_idx_reg == WW'(WORDS - 1));
    assign status.last_table = (table_reg == TW'(TABLES - 1));

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            table_reg    <= '0;
            base_reg     <= '0;
            map_addr_reg <= '0;
            word_idx_reg <= '0;
            run_reg      <= '0;
        end
        else
        begin
            if (cmd.clr_step && !status.clr_done)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.load)
            begin
                table_reg    <= '0;
                base_reg     <= '0;
                map_addr_reg <= '0;
            end
            else if (cmd.next_table)
            begin
                table_reg    <= table_reg + 1'b1;
                base_reg     <= base_reg + AW'(WORDS);
                map_addr_reg <= base_reg + AW'(WORDS);
            end
            else if (cmd.scan_step)
            begin
                map_addr_reg <= map_addr_reg + 1'b1;
            end
            if (cmd.scan_start)
            begin
                word_idx_reg <= '0;
                run_reg      <= '0;
            end
            else if (cmd.scan_step)
            begin
                word_idx_reg <= word_idx_reg + 1'b1;
                run_reg      <= run_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= op;
            table_sel_reg <= table_sel;
            entry_sel_reg <= entry_sel;
            want_reg      <= page_count;
            hit_found_reg <= 1'b0;
            hit_table_reg <= '0;
            hit_entry_reg <= '0;
        end
        else if (cmd.scan_eval && status.hit)
        begin
            hit_found_reg <= 1'b1;
            hit_table_reg <= cfpf_pkg::TSEL_W'(table_reg);
            hit_entry_reg <= cfpf_pkg::ESEL_W'(start_sum);
        end
        if (cmd.out_load)
        begin
            found_reg        <= hit_found_reg;
            result_table_reg <= hit_table_reg;
            result_entry_reg <= hit_entry_reg;
        end
    end

    assign found        = found_reg;
    assign result_table = result_table_reg;
    assign result_entry = result_entry_reg;

    `CFPF_ASSERT_NOW(a_carry_below_want, clk, rst_n, cmd.scan_eval, run_reg < want_reg, "carried run reached request without a hit")
    `CFPF_ASSERT_NOW(a_count_in_range, clk, rst_n, map_we, 32'(cnt_wdata) <= ENTRIES, "used count left its range")

endmodule

FILE: rtl/contiguous_free_page_finder.sv
// Top level of the contiguous free page finder.
// Usage:
//   Request channel (req_valid/req_ready) carries op, table_sel, entry_sel and
//   page_count. op find searches tables in order for the first run of
//   page_count free entries; op mark used / mark free set or clear one entry.
//   Result channel (res_valid/res_ready) carries found, result_table and
//   result_entry; exactly one result per request, zero for marks.
// Flow: a mark reads the map word and used count, writes both back if the
//   entry is in range and its bit changes, then reports. A find reads each
//   table's used count, skips a table short of free entries, and scans the
//   32-bit map words of the rest, one map memory word per cycle, to report.
//   One request is in work at a time; the next is taken once the result is
//   in the output register, even while that result still waits.
// Reset: the map memory, TABLES * ceil(ENTRIES/32) words (2048 by default),
//   is swept to zero, one word a cycle; req_ready stays low until the sweep
//   ends.
// Stall: a result not taken holds in the output register; a finished
//   request then waits for the register to drain before the next is taken.
module contiguous_free_page_finder #(
    parameter int TABLES  = 64,
    parameter int ENTRIES = 1024
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  logic [cfpf_pkg::OP_W-1:0]        op,
    input  logic [cfpf_pkg::TSEL_W-1:0]      table_sel,
    input  logic [cfpf_pkg::ESEL_W-1:0]      entry_sel,
    input  logic [cfpf_pkg::CNT_W-1:0]       page_count,
    output logic                             res_valid,
    input  logic                             res_ready,
    output logic                             found,
    output logic [cfpf_pkg::TSEL_W-1:0]      result_table,
    output logic [cfpf_pkg::ESEL_W-1:0]      result_entry
);

    cfpf_pkg::cmd_t    cmd;
    cfpf_pkg::status_t status;

    // Sequence the clear sweep, marks and the table-by-table scan.
    cfpf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (op),
        .req_ready (req_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold the used map, per-table used counts and the word scanner.
    cfpf_dpath #(
        .TABLES  (TABLES),
        .ENTRIES (ENTRIES)
    ) u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .op           (op),
        .table_sel    (table_sel),
        .entry_sel    (entry_sel),
        .page_count   (page_count),
        .found        (found),
        .result_table (result_table),
        .result_entry (result_entry)
    );

endmodule

FILE: verif/contiguous_free_page_finder_tb.sv
// Self-checking testbench for the contiguous free page finder: directed plan, then random traffic.
`timescale 1ns / 100ps

module contiguous_free_page_finder_tb;

    localparam int TABLES     = 64;
    localparam int ENTRIES    = 1024;
    localparam int TSEL_W     = cfpf_pkg::TSEL_W;
    localparam int ESEL_W     = cfpf_pkg::ESEL_W;
    localparam int CNT_W      = cfpf_pkg::CNT_W;
    localparam int RAND_REQS  = 2000;
    // Longest correct quiet spell: the reset sweep, a find that scans every table,
    // a long result stall and a long sender gap. Take that several times over.
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 100;
    localparam int PLAN_LEN   = 25;
    localparam cfpf_pkg::op_t OP_UNUSED = 2'd3;

    typedef struct packed {
        logic              hit;
        logic [TSEL_W-1:0] tab;
        logic [ESEL_W-1:0] ent;
    } result_t;

    typedef struct packed {
        cfpf_pkg::op_t     op;
        logic [TSEL_W-1:0] tsel;
        logic [ESEL_W-1:0] esel;
        logic [CNT_W-1:0]  want;
        logic              fixed;
        result_t           res;
    } plan_row_t;

    localparam result_t NO_RESULT  = '0;
    localparam result_t HIT_ORIGIN = {1'b1, 16'd0};

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              req_valid  = 1'b0;
    logic              req_ready;
    cfpf_pkg::op_t     op         = cfpf_pkg::OP_FIND;
    logic [TSEL_W-1:0] table_sel  = '0;
    logic [ESEL_W-1:0] entry_sel  = '0;
    logic [CNT_W-1:0]  page_count = '0;
    logic              res_valid;
    logic              res_ready  = 1'b0;
    logic              found;
    logic [TSEL_W-1:0] result_table;
    logic [ESEL_W-1:0] result_entry;

    // Shadow of the allocator: one used bit per entry and a used tally per table.
    logic [ENTRIES-1:0] used_bits  [TABLES];
    logic [CNT_W-1:0]   used_tally [TABLES];
    result_t            pending_results [$];
    // Entries marked used by random traffic; most random frees pick from here.
    logic [TSEL_W+ESEL_W-1:0] marked_list [$];

    bit quiet = 1'b0;
    int errors       = 0;
    int results_seen = 0;
    int idle_cycles  = 0;
    int n_requests   = 0;
    int n_finds      = 0;
    int n_hits       = 0;
    int n_marks      = 0;
    int deepest_hit  = -1;

    // Directed plan. Rows with fixed set carry a result that is plain from the map
    // state at that point; the rest are checked against the shadow.
    plan_row_t plan [PLAN_LEN] = '{
        // fresh map: any fitting request lands on the first entry of the first table
        {cfpf_pkg::OP_FIND,      6'd0,  10'd0,    11'd1,    1'b1, HIT_ORIGIN},
        // zero pages never match
        {cfpf_pkg::OP_FIND,      6'd0,  10'd0,    11'd0,    1'b1, NO_RESULT},
        // a whole table
        {cfpf_pkg::OP_FIND,      6'd0,  10'd0,    11'd1024, 1'b1, HIT_ORIGIN},
        // more than a table holds, then the widest code with all-ones selectors
        {cfpf_pkg::OP_FIND,      6'd0,  10'd0,    11'd1025, 1'b1, NO_RESULT},
        {cfpf_pkg::OP_FIND,      6'd63, 10'd1023, 11'd2047, 1'b1, NO_RESULT},
        // mark the same entry twice; the second must leave the tally alone
        {cfpf_pkg::OP_MARK_USED, 6'd0,  10'd0,    11'd0,    1'b1, NO_RESULT},
        {cfpf_pkg::OP_MARK_USED, 6'd0,  10'd0,    11'd0,    1'b1, NO_RESULT},
        {cfpf_pkg::OP_FIND,      6'd0,  10'd0,    11'd1,    1'b0, NO_RESULT},
        // table 0 is now skipped on its tally
        {cfpf_pkg::OP_FIND,      6'd0,  10'd0,    11'd1024, 1'b0, NO_RESULT},
        {cfpf_pkg::OP_MARK_USED, 6'd63, 10'd1023, 11'd2047, 1'b1, NO_RESULT},
        {cfpf_pkg::OP_MARK_USED, 6'd0,  10'd1023, 11'd0,    1'b1, NO_RESULT},
        // run squeezed between the two used ends of table 0
        {cfpf_pkg::OP_FIND,      6'd0,  10'd0,    11'd1022, 1'b0, NO_RESULT},
        {cfpf_pkg::OP_FIND,      6'd0,  10'd0,    11'd1023, 1'b0, NO_RESULT},
        // free twice; the second is a no-op
        {cfpf_pkg::OP_MARK_FREE, 6'd0,  10'd0,    11'd0,    1'b1, NO_RESULT},
        {cfpf_pkg::OP_MARK_FREE, 6'd0,  10'd0,    11'd0,    1'b1, NO_RESULT},
        {OP_UNUSED,              6'd5,  10'd5,    11'd7,    1'b1, NO_RESULT},
        // used entries on both sides of a map word boundary
        {cfpf_pkg::OP_MARK_USED, 6'd0,  10'd31,   11'd0,    1'b1, NO_RESULT},
        {cfpf_pkg::OP_MARK_USED, 6'd0,  10'd32,   11'd0,    1'b1, NO_RESULT},
        {cfpf_pkg::OP_FIND,      6'd0,  10'd0,    11'd31,   1'b0, NO_RESULT},
        {cfpf_pkg::OP_FIND,      6'd0,  10'd0,    11'd32,   1'b0, NO_RESULT},
        {cfpf_pkg::OP_MARK_FREE, 6'd63, 10'd1023, 11'd0,    1'b1, NO_RESULT},
        {cfpf_pkg::OP_MARK_USED, 6'd1,  10'd512,  11'd0,    1'b1, NO_RESULT},
        // tables 0 and 1 both fall out on their tallies
        {cfpf_pkg::OP_FIND,      6'd0,  10'd0,    11'd1024, 1'b0, NO_RESULT},
        {OP_UNUSED,              6'd63, 10'd1023, 11'd2047, 1'b1, NO_RESULT},
        {cfpf_pkg::OP_FIND,      6'd0,  10'd0,    11'd1,    1'b0, NO_RESULT}
    };

    contiguous_free_page_finder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .op           (op),
        .table_sel    (table_sel),
        .entry_sel    (entry_sel),
        .page_count   (page_count),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .found        (found),
        .result_table (result_table),
        .result_entry (result_entry)
    );

    always #1 clk = ~clk;

    task automatic note_failure(string msg);
        errors++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // First-fit search over the shadow map: skip tables whose free tally is short,
    // then walk the entries for the first long enough run.
    function automatic result_t find_free_run(logic [CNT_W-1:0] want);
        result_t r;
        int run;
        int start;
        r = '0;
        if (want == 0 || want > ENTRIES)
            return r;
        for (int t = 0; t < TABLES; t++)
        begin
            if (ENTRIES - int'(used_tally[t]) < int'(want))
                continue;
            run = 0;
            start = 0;
            for (int e = 0; e < ENTRIES; e++)
            begin
                if (used_bits[t][e])
                    run = 0;
                else
                begin
                    if (run == 0)
                        start = e;
                    run++;
                    if (run == int'(want))
                    begin
                        r.hit = 1'b1;
                        r.tab = t[TSEL_W-1:0];
                        r.ent = start[ESEL_W-1:0];
                        return r;
                    end
                end
            end
        end
        return r;
    endfunction

    // Advance the shadow by one request and return the result it should give.
    function automatic result_t apply_request(cfpf_pkg::op_t code,
                                              logic [TSEL_W-1:0] tsel,
                                              logic [ESEL_W-1:0] esel,
                                              logic [CNT_W-1:0] want);
        result_t r;
        r = '0;
        case (code)
            cfpf_pkg::OP_FIND:
                r = find_free_run(want);
            cfpf_pkg::OP_MARK_USED:
                if (!used_bits[tsel][esel])
                begin
                    used_bits[tsel][esel] = 1'b1;
                    used_tally[tsel] = used_tally[tsel] + 1'b1;
                end
            cfpf_pkg::OP_MARK_FREE:
                if (used_bits[tsel][esel])
                begin
                    used_bits[tsel][esel] = 1'b0;
                    used_tally[tsel] = used_tally[tsel] - 1'b1;
                end
            default:
                ;
        endcase
        return r;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Request sizes lean small; large ones exercise tally skips and full-table scans.
    function automatic logic [CNT_W-1:0] request_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            return '0;
        if (pick < 45)
            return CNT_W'($urandom_range(1, 16));
        if (pick < 75)
            return CNT_W'($urandom_range(17, 256));
        if (pick < 90)
            return CNT_W'($urandom_range(257, ENTRIES - 1));
        return CNT_W'($urandom_range(ENTRIES - 24, ENTRIES));
    endfunction

    // Present one request at a falling edge, hold it until taken, then record
    // what the result must be.
    task automatic send_request(cfpf_pkg::op_t code, logic [TSEL_W-1:0] tsel,
                                logic [ESEL_W-1:0] esel, logic [CNT_W-1:0] want,
                                logic fixed, result_t fixed_res);
        int gap;
        result_t predicted;
        gap = quiet ? 0 : idle_length();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        op         <= code;
        table_sel  <= tsel;
        entry_sel  <= esel;
        page_count <= want;
        req_valid  <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = apply_request(code, tsel, esel, want);
        pending_results.push_back(fixed ? fixed_res : predicted);
        n_requests++;
        if (code == cfpf_pkg::OP_FIND)
        begin
            n_finds++;
            if (predicted.hit)
            begin
                n_hits++;
                if (int'(predicted.tab) > deepest_hit)
                    deepest_hit = int'(predicted.tab);
            end
        end
        else if (code != OP_UNUSED)
            n_marks++;
    endtask

    // Drop valid and hold off until every outstanding result has been taken.
    task automatic hold_until_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Marks cluster on the first four tables so finds meet fragmented maps there;
    // one in ten lands anywhere. Unused fields carry random noise.
    task automatic send_random_request();
        int pick;
        int slot;
        cfpf_pkg::op_t code;
        logic [TSEL_W-1:0] tsel;
        logic [ESEL_W-1:0] esel;
        logic [CNT_W-1:0] want;
        pick = $urandom_range(0, 99);
        tsel = ($urandom_range(0, 9) == 0) ? TSEL_W'($urandom_range(0, TABLES - 1))
                                           : TSEL_W'($urandom_range(0, 3));
        esel = ESEL_W'($urandom_range(0, ENTRIES - 1));
        want = CNT_W'($urandom_range(0, ENTRIES));
        if (pick < 45)
        begin
            code = cfpf_pkg::OP_MARK_USED;
            marked_list.push_back({tsel, esel});
        end
        else if (pick < 65)
        begin
            code = cfpf_pkg::OP_MARK_FREE;
            if (marked_list.size() != 0 && $urandom_range(0, 9) < 7)
            begin
                slot = $urandom_range(0, marked_list.size() - 1);
                {tsel, esel} = marked_list[slot];
                marked_list.delete(slot);
            end
        end
        else if (pick < 99)
        begin
            code = cfpf_pkg::OP_FIND;
            want = request_size();
        end
        else
            code = OP_UNUSED;
        send_request(code, tsel, esel, want, 1'b0, NO_RESULT);
    endtask

    initial
    begin : stimulus
        for (int t = 0; t < TABLES; t++)
        begin
            used_bits[t]  = '0;
            used_tally[t] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PLAN_LEN; i++)
            send_request(plan[i].op, plan[i].tsel, plan[i].esel, plan[i].want,
                         plan[i].fixed, plan[i].res);
        hold_until_drained();

        for (int n = 0; n < RAND_REQS; n++)
        begin
            // Switch now and then into a stretch with no idling on either side.
            if (n % 150 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 99) == 0)
                hold_until_drained();
            send_random_request();
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // Give a stray extra result time to show up.
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Run covered %0d requests: %0d finds (%0d hits, deepest hit in table %0d),",
                 n_requests, n_finds, n_hits, deepest_hit);
        $display("%0d marks; results compared: %0d, errors: %0d.",
                 n_marks, results_seen, errors);
        if (errors == 0)
            $display("contiguous_free_page_finder verification clean");
        else
            $display("contiguous_free_page_finder verification failed");
        $finish;
    end

    // Result side: runs of ready, short stalls and the odd long stall.
    initial
    begin : result_sink
        int pick;
        int span;
        logic level;
        forever
        begin
            pick = $urandom_range(0, 99);
            if (quiet || pick < 50)
            begin
                level = 1'b1;
                span  = $urandom_range(1, 20);
            end
            else if (pick < 88)
            begin
                level = 1'b0;
                span  = $urandom_range(1, 4);
            end
            else
            begin
                level = 1'b0;
                span  = $urandom_range(20, 60);
            end
            @(negedge clk);
            res_ready <= level;
            repeat (span - 1) @(negedge clk);
        end
    end

    // Compare each taken result with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        result_t exp_r;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
                note_failure($sformatf("result with no request outstanding: %s=%0b %s=%0d %s=%0d",
                                       "found", found, "table", result_table,
                                       "entry", result_entry));
            else
            begin
                exp_r = pending_results.pop_front();
                results_seen++;
                if (found !== exp_r.hit)
                    note_failure($sformatf("found %0b, expected %0b", found, exp_r.hit));
                if (result_table !== exp_r.tab)
                    note_failure($sformatf("result_table %0d, expected %0d",
                                           result_table, exp_r.tab));
                if (result_entry !== exp_r.ent)
                    note_failure($sformatf("result_entry %0d, expected %0d",
                                           result_entry, exp_r.ent));
            end
        end
    end

    // Stop a hung run: count cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("contiguous_free_page_finder verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

FILE: contiguous_free_page_finder.f
+incdir+rtl
rtl/cfpf_pkg.sv
rtl/cfpf_ctrl.sv
rtl/cfpf_dpath.sv
rtl/contiguous_free_page_finder.sv
verif/contiguous_free_page_finder_tb.sv
